// File: rtl/core/lhm_pkg.sv
// Shared types and constants of the latency histogram monitor.
package lhm_pkg;

	// Field widths fixed by the interface.
	localparam int LAT_W    = 24;
	localparam int CFG_W    = 23;
	localparam int BIN_IDX_W = 10;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 48;
	localparam int CFG_IDX_W = 1;

	// Width that holds any bin index or bin count in the supported range.
	localparam int IDX_EXT_W = 17;

	// Operation codes of an input item.
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

	// Register reset values.
	localparam logic [CFG_W-1:0] PERIOD_RST    = 23'd1000;
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 23'd1023;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;    // latch the accepted item
		logic clear_stats;  // clear statistics registers and flags
		logic rd_en;        // issue a histogram read
		logic rd_sel_item;  // read address from the latched item
		logic sweep;        // write zero to the next bin of the clearing pass
		logic exec;         // finish the item and load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_clear;     // offered item is a record item with clear_first
		logic sweep_last;   // clearing pass is at the last bin
	} status_t;

endpackage

// File: rtl/core/latency_histogram_monitor_top.sv
// Latency histogram monitor: statistics of measured latencies with a bin memory.
// A result is registered when its item finishes and the result slot is free;
// the next item waits until then, paced by the histogram memory read-modify-write.
// A record item with clear_first adds a sweep of all HIST_BINS bins plus a bin fetch.
// After reset a clearing pass over all HIST_BINS bins runs with in_ready low;
// configuration writes are taken during it and registers reset to their defaults.
module latency_histogram_monitor_top #(
	parameter int HIST_BINS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lhm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lhm_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic                                clear_first,
	input  logic signed [lhm_pkg::LAT_W-1:0]    latency,
	input  logic [lhm_pkg::BIN_IDX_W-1:0]       bin_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lhm_pkg::CNT_W-1:0]           sample_count,
	output logic signed [lhm_pkg::SUM_W-1:0]    latency_total,
	output logic [lhm_pkg::CNT_W-1:0]           late_count,
	output logic [lhm_pkg::SUM_W-1:0]           late_excess_total,
	output logic signed [lhm_pkg::LAT_W-1:0]    max_latency,
	output logic                                alert_event,
	output logic                                over_period_mark,
	output logic [lhm_pkg::CNT_W-1:0]           bin_value
);

	lhm_pkg::cmd_t    cmd;
	lhm_pkg::status_t status;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	lhm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lhm_dp #(
		.HIST_BINS(HIST_BINS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.clear_first      (clear_first),
		.latency          (latency),
		.bin_index        (bin_index),
		.sample_count     (sample_count),
		.latency_total    (latency_total),
		.late_count       (late_count),
		.late_excess_total(late_excess_total),
		.max_latency      (max_latency),
		.alert_event      (alert_event),
		.over_period_mark (over_period_mark),
		.bin_value        (bin_value)
	);

`ifndef SYNTHESIS
	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted item");

	// No item is taken while the memory is being cleared.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !in_ready)
		else $error("input ready during the clearing pass");

	// Finishing an item always presents a result in the next cycle.
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("finished item without a valid result");

	// A finished item never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !out_valid || out_ready)
		else $error("result register overwritten before it was taken");
`endif

endmodule

// File: rtl/core/lhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/lhm_ctrl.sv
// Controller state machine of the latency histogram monitor.
module lhm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lhm_pkg::status_t status,
	output lhm_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       pend_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd             = '0;
		cmd.load_item   = accept;
		cmd.clear_stats = accept && status.in_clear;
		cmd.rd_en       = (accept && !status.in_clear) || (state_q == ST_FETCH);
		cmd.rd_sel_item = (state_q == ST_FETCH);
		cmd.sweep       = (state_q == ST_CLEAR);
		cmd.exec        = (state_q == ST_EXEC) && slot_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.sweep_last) begin
					state_d = pend_q ? ST_FETCH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = status.in_clear ? ST_CLEAR : ST_EXEC;
				end
			end
			ST_FETCH: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State, pending-item flag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clear_stats) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_FETCH) begin
				pend_q <= 1'b0;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/lhm_dp.sv
// Datapath of the latency histogram monitor: histogram memory and statistics.
module lhm_dp #(
	parameter int HIST_BINS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lhm_pkg::cmd_t                       cmd,
	output lhm_pkg::status_t                    status,
	input  logic                                cfg_valid,
	input  logic [lhm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lhm_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                operation,
	input  logic                                clear_first,
	input  logic signed [lhm_pkg::LAT_W-1:0]    latency,
	input  logic [lhm_pkg::BIN_IDX_W-1:0]       bin_index,
	output logic [lhm_pkg::CNT_W-1:0]           sample_count,
	output logic signed [lhm_pkg::SUM_W-1:0]    latency_total,
	output logic [lhm_pkg::CNT_W-1:0]           late_count,
	output logic [lhm_pkg::SUM_W-1:0]           late_excess_total,
	output logic signed [lhm_pkg::LAT_W-1:0]    max_latency,
	output logic                                alert_event,
	output logic                                over_period_mark,
	output logic [lhm_pkg::CNT_W-1:0]           bin_value
);

	localparam int BIN_W = $clog2(HIST_BINS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);
	localparam logic [lhm_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(lhm_pkg::SUM_W-1){1'b1}}};
	localparam logic [lhm_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(lhm_pkg::SUM_W-1){1'b0}}};

	// Configuration registers.
	logic [lhm_pkg::CFG_W-1:0] period_q;
	logic [lhm_pkg::CFG_W-1:0] thresh_q;

	// Latched item.
	logic                       item_op_q;
	logic [lhm_pkg::LAT_W-1:0]  item_lat_q;
	logic [BIN_W-1:0]           item_addr_q;
	logic                       item_in_range_q;

	// Statistics.
	logic [lhm_pkg::CNT_W-1:0]  count_q;
	logic [lhm_pkg::SUM_W-1:0]  sum_q;
	logic [lhm_pkg::CNT_W-1:0]  late_cnt_q;
	logic [lhm_pkg::SUM_W-1:0]  excess_q;
	logic [lhm_pkg::LAT_W-1:0]  max_q;
	logic                       late_armed_q;
	logic                       alert_armed_q;

	// Clearing pass counter.
	logic [BIN_W-1:0]           sweep_addr_q;

	// Input-side address decode.
	logic [lhm_pkg::IDX_EXT_W-1:0] bin_ext;
	logic                          rd_in_range;
	logic                          lat_in_range;
	logic [BIN_W-1:0]              in_addr;

	// Memory signals.
	logic                       ram_wr_en;
	logic [BIN_W-1:0]           ram_wr_addr;
	logic [lhm_pkg::CNT_W-1:0]  ram_wr_data;
	logic [BIN_W-1:0]           ram_rd_addr;
	logic [lhm_pkg::CNT_W-1:0]  ram_rd_data;
	logic [lhm_pkg::CNT_W-1:0]  hist_inc;

	// Next statistics for a record item.
	logic                       rec;
	logic [lhm_pkg::SUM_W:0]    sum_wide;
	logic [lhm_pkg::SUM_W-1:0]  sum_d;
	logic [lhm_pkg::LAT_W:0]    per_diff;
	logic [lhm_pkg::LAT_W:0]    thr_diff;
	logic [lhm_pkg::SUM_W:0]    exc_wide;
	logic                       late_hit;
	logic                       alert_hit;
	logic [lhm_pkg::CNT_W-1:0]  count_d;
	logic [lhm_pkg::CNT_W-1:0]  late_cnt_d;
	logic [lhm_pkg::SUM_W-1:0]  excess_d;
	logic [lhm_pkg::LAT_W-1:0]  max_d;
	logic                       over_d;

	// Status to the controller.
	assign status.in_clear   = (operation == lhm_pkg::OP_RECORD) && clear_first;
	assign status.sweep_last = (sweep_addr_q == LAST_BIN);

	// Address of the offered item: a read bin, or the bin a latency falls in.
	assign bin_ext      = lhm_pkg::IDX_EXT_W'(bin_index);
	assign rd_in_range  = bin_ext < lhm_pkg::IDX_EXT_W'(HIST_BINS);
	assign lat_in_range = !latency[lhm_pkg::LAT_W-1] && (latency != '0)
		&& (latency < lhm_pkg::LAT_W'(HIST_BINS));
	always_comb begin
		if (operation == lhm_pkg::OP_READ) begin
			in_addr = rd_in_range ? bin_ext[BIN_W-1:0] : '0;
		end else begin
			in_addr = lat_in_range ? latency[BIN_W-1:0] : '0;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= lhm_pkg::PERIOD_RST;
			thresh_q <= lhm_pkg::THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lhm_pkg::REG_PERIOD:    period_q <= cfg_data;
				lhm_pkg::REG_THRESHOLD: thresh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Item latch.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_op_q       <= operation;
			item_lat_q      <= latency;
			item_addr_q     <= in_addr;
			item_in_range_q <= rd_in_range;
		end
	end

	// Clearing pass counter wraps to zero after the last bin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
		end else if (cmd.sweep) begin
			sweep_addr_q <= status.sweep_last ? '0 : sweep_addr_q + 1'b1;
		end
	end

	// Histogram memory: sweep writes zeros, a record item writes the bumped count.
	assign rec         = (item_op_q == lhm_pkg::OP_RECORD);
	assign hist_inc    = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
	assign ram_wr_en   = cmd.sweep || (cmd.exec && rec);
	assign ram_wr_addr = cmd.sweep ? sweep_addr_q : item_addr_q;
	assign ram_wr_data = cmd.sweep ? '0 : hist_inc;
	assign ram_rd_addr = cmd.rd_sel_item ? item_addr_q : in_addr;

	lhm_ram #(
		.WIDTH(lhm_pkg::CNT_W),
		.DEPTH(HIST_BINS)
	) u_hist (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Sample count and saturating signed running sum.
	assign count_d  = (count_q == '1) ? count_q : count_q + 1'b1;
	assign sum_wide = {sum_q[lhm_pkg::SUM_W-1], sum_q}
		+ {{(lhm_pkg::SUM_W-lhm_pkg::LAT_W+1){item_lat_q[lhm_pkg::LAT_W-1]}}, item_lat_q};
	always_comb begin
		if (sum_wide[lhm_pkg::SUM_W] != sum_wide[lhm_pkg::SUM_W-1]) begin
			sum_d = sum_wide[lhm_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_d = sum_wide[lhm_pkg::SUM_W-1:0];
		end
	end

	// Exact signed compares against the limits; a negative difference means below.
	assign per_diff = {item_lat_q[lhm_pkg::LAT_W-1], item_lat_q} - {2'b00, period_q};
	assign thr_diff = {item_lat_q[lhm_pkg::LAT_W-1], item_lat_q} - {2'b00, thresh_q};
	assign late_hit  = !per_diff[lhm_pkg::LAT_W] && !late_armed_q;
	assign alert_hit = !thr_diff[lhm_pkg::LAT_W] && !alert_armed_q;
	assign over_d    = !per_diff[lhm_pkg::LAT_W] && (per_diff != '0);

	// Lateness count and saturating excess total on a rising crossing.
	assign exc_wide = {1'b0, excess_q}
		+ {{(lhm_pkg::SUM_W-lhm_pkg::LAT_W+1){1'b0}}, per_diff[lhm_pkg::LAT_W-1:0]};
	always_comb begin
		late_cnt_d = late_cnt_q;
		excess_d   = excess_q;
		if (late_hit) begin
			late_cnt_d = (late_cnt_q == '1) ? late_cnt_q : late_cnt_q + 1'b1;
			excess_d   = exc_wide[lhm_pkg::SUM_W] ? '1 : exc_wide[lhm_pkg::SUM_W-1:0];
		end
	end

	// Running maximum.
	assign max_d = ($signed(item_lat_q) > $signed(max_q)) ? item_lat_q : max_q;

	// Statistics registers: cleared when a record item with clear_first is accepted, updated when a record item finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			sum_q         <= '0;
			late_cnt_q    <= '0;
			excess_q      <= '0;
			max_q         <= '0;
			late_armed_q  <= 1'b0;
			alert_armed_q <= 1'b0;
		end else begin
			priority if (cmd.clear_stats) begin
				count_q       <= '0;
				sum_q         <= '0;
				late_cnt_q    <= '0;
				excess_q      <= '0;
				max_q         <= '0;
				late_armed_q  <= 1'b0;
				alert_armed_q <= 1'b0;
			end else if (cmd.exec && rec) begin
				count_q       <= count_d;
				sum_q         <= sum_d;
				late_cnt_q    <= late_cnt_d;
				excess_q      <= excess_d;
				max_q         <= max_d;
				late_armed_q  <= !per_diff[lhm_pkg::LAT_W];
				alert_armed_q <= !thr_diff[lhm_pkg::LAT_W];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (rec) begin
				sample_count      <= count_d;
				latency_total     <= sum_d;
				late_count        <= late_cnt_d;
				late_excess_total <= excess_d;
				max_latency       <= max_d;
				alert_event       <= alert_hit;
				over_period_mark  <= alert_hit && over_d;
				bin_value         <= '0;
			end else begin
				sample_count      <= count_q;
				latency_total     <= sum_q;
				late_count        <= late_cnt_q;
				late_excess_total <= excess_q;
				max_latency       <= max_q;
				alert_event       <= 1'b0;
				over_period_mark  <= 1'b0;
				bin_value         <= item_in_range_q ? ram_rd_data : '0;
			end
		end
	end

endmodule
